/* rtl/fmn_pkg.sv */
// Package for the frequency to note converter.
// Holds ratio codes and constants, sequencer states and register indexes.
// No dependencies.
package fmn_pkg;

  localparam int unsigned Q_BITS  = 24;
  localparam int unsigned K_W     = 25;

  localparam logic [K_W-1:0] K_SEMI_UP = 25'd17774841;
  localparam logic [K_W-1:0] K_SEMI_DN = 25'd15835583;
  localparam logic [K_W-1:0] K_CENT_UP = 25'd16786910;
  localparam logic [K_W-1:0] K_CENT_DN = 25'd16767528;

  localparam logic signed [8:0] SEMI_LIMIT = 9'sd128;
  localparam logic [6:0]        CENT_LIMIT = 7'd120;
  localparam logic [6:0]        CENT_HALF  = 7'd50;

  localparam logic [8:0] REF_FREQ_RST = 9'd440;
  localparam logic [6:0] REF_NOTE_RST = 7'd57;
  localparam logic [6:0] NOTE_MAX     = 7'd127;

  typedef enum logic [1:0] {
    RATIO_SEMI_UP,
    RATIO_SEMI_DN,
    RATIO_CENT_UP,
    RATIO_CENT_DN
  } ratio_t;

  typedef enum logic {
    CFG_REF_FREQ,
    CFG_REF_NOTE
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEMI_MUL,
    ST_SEMI_WAIT,
    ST_CENT_MUL,
    ST_CENT_WAIT,
    ST_ROUND,
    ST_DONE
  } state_t;

  function automatic logic [K_W-1:0] ratio_k(input ratio_t r);
    logic [K_W-1:0] k;
    case (r)
      RATIO_SEMI_UP: k = K_SEMI_UP;
      RATIO_SEMI_DN: k = K_SEMI_DN;
      RATIO_CENT_UP: k = K_CENT_UP;
      RATIO_CENT_DN: k = K_CENT_DN;
      default:       k = K_SEMI_UP;
    endcase
    return k;
  endfunction

endpackage

/* rtl/fmn_qmul.sv */
// Shared Q.24 ratio multiplier with round to nearest.
// One 24x25 multiplier serves the low half, then the high half of f.
// Depends on fmn_pkg.
module fmn_qmul #(
  parameter int unsigned FW = 40
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  fmn_pkg::ratio_t   ratio,
  input  logic [FW-1:0]     f,
  output logic              done,
  output logic [FW-1:0]     p
);
  import fmn_pkg::*;

  localparam int unsigned PW = Q_BITS + K_W;

  logic              hi_r, hi_nxt;
  logic              done_r, done_nxt;
  logic [K_W-1:0]    acc_r, acc_nxt;
  logic [FW-1:0]     p_r, p_nxt;
  logic [Q_BITS-1:0] op;
  logic [K_W-1:0]    k;
  logic [PW-1:0]     prod;
  logic [PW-1:0]     prod_rnd;

  always_comb begin
    k        = ratio_k(ratio);
    op       = hi_r ? Q_BITS'(f[FW-1:Q_BITS]) : f[Q_BITS-1:0];
    prod     = PW'(op) * PW'(k);
    prod_rnd = prod + (PW'(1) << (Q_BITS - 1));
    acc_nxt  = prod_rnd[PW-1:Q_BITS];
    p_nxt    = hi_r ? (prod[FW-1:0] + FW'(acc_r)) : p_r;
    hi_nxt   = hi_r ? 1'b0 : go;
    done_nxt = hi_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      hi_r   <= hi_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
    p_r   <= p_nxt;
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

/* rtl/frequency_to_midi_note.sv */
// Frequency to note number converter, top level with the step sequencer.
// Depends on fmn_pkg and fmn_qmul.
//
// An item is taken when start is high and busy is low; busy then stays high
// until the result is issued. Each multiplication by a semitone or cent ratio
// goes through one shared multiplier, followed by the compare. The result
// shows on out_note and out_saturated for one cycle with out_valid, in the
// same cycle that busy drops, and cannot be held off: take it when out_valid
// is high.
module frequency_to_midi_note #(
  parameter int unsigned INPUT_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [22:0] in_frequency,
  output logic        out_valid,
  output logic [6:0]  out_note,
  output logic        out_saturated,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);
  import fmn_pkg::*;

  localparam int unsigned SHIFT = Q_BITS - INPUT_FRAC_BITS;
  localparam int unsigned XW    = 23 + SHIFT;
  localparam int unsigned F0W   = 9 + Q_BITS;
  localparam int unsigned FW    = ((XW > F0W) ? XW : F0W) + 1;

  state_t state_r, state_nxt;

  logic [8:0]        ref_freq_r;
  logic [6:0]        ref_note_r;
  logic [FW-1:0]     x_r, x_nxt;
  logic [FW-1:0]     f_r, f_nxt;
  logic              up_r, up_nxt;
  logic              zero_r, zero_nxt;
  logic signed [8:0] semis_r, semis_nxt;
  logic [6:0]        cents_r, cents_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [6:0]        out_note_r, out_note_nxt;
  logic              out_sat_r, out_sat_nxt;

  logic [FW-1:0]     x_in;
  logic [FW-1:0]     f_in;
  logic              mul_go;
  logic              mul_done;
  ratio_t            mul_ratio;
  logic [FW-1:0]     p;
  logic              semi_take;
  logic              semi_at_lim;
  logic              cent_take;
  logic signed [FW:0] d_a;
  logic signed [FW:0] d_b;
  logic              bump;
  logic [6:0]        cents_fin;
  logic signed [9:0] note_sum;

  assign x_in = FW'({in_frequency, {SHIFT{1'b0}}});
  assign f_in = FW'({ref_freq_r, {Q_BITS{1'b0}}});

  fmn_qmul #(
    .FW(FW)
  ) u_qmul (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (mul_go),
    .ratio(mul_ratio),
    .f    (f_r),
    .done (mul_done),
    .p    (p)
  );

  always_comb begin
    semi_at_lim = up_r ? (semis_r == SEMI_LIMIT) : (semis_r == -SEMI_LIMIT);
    semi_take   = !semi_at_lim && (up_r ? (x_r >= p) : (x_r <= p));
    cent_take   = (cents_r != CENT_LIMIT) && (up_r ? (x_r > p) : (x_r < p));
    d_a  = up_r ? ($signed({1'b0, p}) - $signed({1'b0, x_r}))
                : ($signed({1'b0, x_r}) - $signed({1'b0, p}));
    d_b  = up_r ? ($signed({1'b0, x_r}) - $signed({1'b0, f_r}))
                : ($signed({1'b0, f_r}) - $signed({1'b0, x_r}));
    bump = d_a < d_b;
    cents_fin = cents_r + {6'd0, bump};
    note_sum  = $signed({3'b000, ref_note_r}) + $signed({semis_r[8], semis_r});
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (x_in == '0) ? ST_DONE : ST_SEMI_MUL;
        end
      end
      ST_SEMI_MUL:  state_nxt = ST_SEMI_WAIT;
      ST_SEMI_WAIT: begin
        if (mul_done) begin
          if (semi_take) begin
            state_nxt = ST_SEMI_MUL;
          end else if (semi_at_lim) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_CENT_MUL;
          end
        end
      end
      ST_CENT_MUL:  state_nxt = ST_CENT_WAIT;
      ST_CENT_WAIT: begin
        if (mul_done) begin
          state_nxt = cent_take ? ST_CENT_MUL : ST_ROUND;
        end
      end
      ST_ROUND:     state_nxt = ST_DONE;
      ST_DONE:      state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_go = (state_r == ST_SEMI_MUL) || (state_r == ST_CENT_MUL);
    if ((state_r == ST_CENT_MUL) || (state_r == ST_CENT_WAIT)) begin
      mul_ratio = up_r ? RATIO_CENT_UP : RATIO_CENT_DN;
    end else begin
      mul_ratio = up_r ? RATIO_SEMI_UP : RATIO_SEMI_DN;
    end
    busy = (state_r != ST_IDLE);
  end

  always_comb begin
    x_nxt         = x_r;
    f_nxt         = f_r;
    up_nxt        = up_r;
    zero_nxt      = zero_r;
    semis_nxt     = semis_r;
    cents_nxt     = cents_r;
    out_valid_nxt = 1'b0;
    out_note_nxt  = out_note_r;
    out_sat_nxt   = out_sat_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          x_nxt     = x_in;
          f_nxt     = f_in;
          up_nxt    = (x_in >= f_in);
          zero_nxt  = (x_in == '0);
          semis_nxt = '0;
          cents_nxt = '0;
        end
      end
      ST_SEMI_WAIT: begin
        if (mul_done && semi_take) begin
          f_nxt     = p;
          semis_nxt = up_r ? (semis_r + 9'sd1) : (semis_r - 9'sd1);
        end
      end
      ST_CENT_WAIT: begin
        if (mul_done && cent_take) begin
          f_nxt     = p;
          cents_nxt = cents_r + 7'd1;
        end
      end
      ST_ROUND: begin
        if (up_r && (cents_fin > CENT_HALF)) begin
          semis_nxt = semis_r + 9'sd1;
        end else if (!up_r && (cents_fin >= CENT_HALF)) begin
          semis_nxt = semis_r - 9'sd1;
        end
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        if (zero_r) begin
          out_note_nxt = '0;
          out_sat_nxt  = 1'b1;
        end else if (note_sum < 10'sd0) begin
          out_note_nxt = '0;
          out_sat_nxt  = 1'b1;
        end else if (note_sum > $signed({3'b000, NOTE_MAX})) begin
          out_note_nxt = NOTE_MAX;
          out_sat_nxt  = 1'b1;
        end else begin
          out_note_nxt = note_sum[6:0];
          out_sat_nxt  = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ref_freq_r  <= REF_FREQ_RST;
      ref_note_r  <= REF_NOTE_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_REF_FREQ: ref_freq_r <= cfg_data;
          CFG_REF_NOTE: ref_note_r <= cfg_data[6:0];
          default: begin
          end
        endcase
      end
    end
    x_r        <= x_nxt;
    f_r        <= f_nxt;
    up_r       <= up_nxt;
    zero_r     <= zero_nxt;
    semis_r    <= semis_nxt;
    cents_r    <= cents_nxt;
    out_note_r <= out_note_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_note      = out_note_r;
  assign out_saturated = out_sat_r;

endmodule
